[hdl/sru_pkg.sv]
// sru_pkg: shared types, codes and helper functions of the shift/rotate unit
// no dependencies; used by sru_ctrl, sru_datapath and shift_rotate_unit
`timescale 1ns / 1ps

package sru_pkg;

    // operand size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;
    localparam logic [1:0] SIZE_MEM  = 2'd3;

    // shift kinds
    localparam logic [1:0] KIND_AS  = 2'd0;
    localparam logic [1:0] KIND_LS  = 2'd1;
    localparam logic [1:0] KIND_ROX = 2'd2;
    localparam logic [1:0] KIND_RO  = 2'd3;

    // opcode bit positions
    localparam int DIR_LEFT_BIT  = 8;
    localparam int COUNT_REG_BIT = 5;

    // emulated cycle figures
    localparam logic [7:0] CYC_BASE    = 8'd6;
    localparam logic [7:0] CYC_MEM     = 8'd8;
    localparam logic [7:0] CYC_ILLEGAL = 8'd4;

    // immediate count of zero stands for eight
    localparam logic [5:0] IMM_ZERO_COUNT = 6'd8;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic count_zero;
    } t_status;

    // value mask for a size code
    function automatic logic [31:0] size_mask(input logic [1:0] size);
        logic [31:0] m;
        unique case (size)
            SIZE_BYTE: m = 32'h0000_00FF;
            SIZE_WORD: m = 32'h0000_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // one-hot sign bit for a size code
    function automatic logic [31:0] sign_mask(input logic [1:0] size);
        logic [31:0] m;
        unique case (size)
            SIZE_BYTE: m = 32'h0000_0080;
            SIZE_WORD: m = 32'h0000_8000;
            default:   m = 32'h8000_0000;
        endcase
        return m;
    endfunction

endpackage

[hdl/shift_rotate_unit.sv]
// shift_rotate_unit: top level of the 68000-style shift/rotate unit
// depends on sru_pkg, sru_ctrl and sru_datapath
`timescale 1ns / 1ps

//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------------
//  input    | start / busy         | i_opcode, i_operand_value, i_count_register,
//           |                      | i_extend_in
//  result   | o_valid (one cycle)  | o_result_value, o_result_size, o_flag_x..o_flag_c,
//           |                      | o_cycle_count, o_illegal
//
//  a transaction loads, then makes one pass of the single-bit shifter per shifted
//  bit (0 to 63), then forms the flags
//  busy is high from the cycle after acceptance until the result strobe
//  o_valid pulses for one cycle; the receiver cannot stall, and a new start is
//  taken in the strobe cycle
//  i_rst_n is synchronous and active low; it clears the controller only

module shift_rotate_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_opcode,
    input  logic [31:0] i_operand_value,
    input  logic [31:0] i_count_register,
    input  logic        i_extend_in,
    output logic        o_valid,
    output logic [31:0] o_result_value,
    output logic [1:0]  o_result_size,
    output logic        o_flag_x,
    output logic        o_flag_n,
    output logic        o_flag_z,
    output logic        o_flag_v,
    output logic        o_flag_c,
    output logic [7:0]  o_cycle_count,
    output logic        o_illegal
);

    sru_pkg::t_cmd    cmd;
    sru_pkg::t_status status;

    // sequencer
    sru_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    // shifter and flags
    sru_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_opcode         (i_opcode),
        .i_operand_value  (i_operand_value),
        .i_count_register (i_count_register),
        .i_extend_in      (i_extend_in),
        .o_result_value   (o_result_value),
        .o_result_size    (o_result_size),
        .o_flag_x         (o_flag_x),
        .o_flag_n         (o_flag_n),
        .o_flag_z         (o_flag_z),
        .o_flag_v         (o_flag_v),
        .o_flag_c         (o_flag_c),
        .o_cycle_count    (o_cycle_count),
        .o_illegal        (o_illegal)
    );

endmodule

[hdl/sru_ctrl.sv]
// sru_ctrl: controller state machine of the shift/rotate unit
// depends on sru_pkg (t_cmd, t_status)
`timescale 1ns / 1ps

module sru_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  sru_pkg::t_status i_status,
    output sru_pkg::t_cmd    o_cmd,
    output logic             busy,
    output logic             o_valid
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state;
    logic   r_valid;

    // commands decoded from the state
    always_comb begin
        o_cmd.load   = (r_state == ST_IDLE) && start;
        o_cmd.step   = (r_state == ST_RUN) && !i_status.count_zero;
        o_cmd.finish = (r_state == ST_RUN) && i_status.count_zero;
    end

    assign busy    = (r_state == ST_RUN);
    assign o_valid = r_valid;

    // state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (i_status.count_zero) begin
                        r_state <= ST_IDLE;
                        r_valid <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // accepted transaction makes the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // the strobe is a single cycle pulse
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // a finished shift delivers its result next cycle
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && i_status.count_zero) |=> (o_valid && !busy))
        else $error("finish did not deliver a result");
`endif

endmodule

[hdl/sru_datapath.sv]
// sru_datapath: decode, bit-serial shifter, flag and cycle-count logic
// depends on sru_pkg (codes, t_cmd, t_status, mask functions)
`timescale 1ns / 1ps

module sru_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sru_pkg::t_cmd    i_cmd,
    output sru_pkg::t_status o_status,
    input  logic [15:0]      i_opcode,
    input  logic [31:0]      i_operand_value,
    input  logic [31:0]      i_count_register,
    input  logic             i_extend_in,
    output logic [31:0]      o_result_value,
    output logic [1:0]       o_result_size,
    output logic             o_flag_x,
    output logic             o_flag_n,
    output logic             o_flag_z,
    output logic             o_flag_v,
    output logic             o_flag_c,
    output logic [7:0]       o_cycle_count,
    output logic             o_illegal
);

    // working registers
    logic [31:0] r_val;
    logic [5:0]  r_count;
    logic [1:0]  r_size;
    logic [1:0]  r_kind;
    logic        r_left;
    logic        r_xin;
    logic        r_x;
    logic        r_c;
    logic        r_v;
    logic        r_zero_cnt;
    logic        r_illegal;
    logic [7:0]  r_cycles;

    // result registers
    logic [31:0] r_res_value;
    logic [1:0]  r_res_size;
    logic        r_res_x;
    logic        r_res_n;
    logic        r_res_z;
    logic        r_res_v;
    logic        r_res_c;
    logic [7:0]  r_res_cycles;
    logic        r_res_illegal;

    // decode of the incoming instruction
    logic        d_mem;
    logic        d_illegal;
    logic [1:0]  d_size;
    logic [1:0]  d_kind;
    logic [5:0]  d_count;
    logic [7:0]  d_cycles;

    always_comb begin
        d_mem     = (i_opcode[7:6] == sru_pkg::SIZE_MEM);
        d_illegal = d_mem && (i_opcode[5:4] == 2'b00);
        d_size    = d_mem ? sru_pkg::SIZE_WORD : i_opcode[7:6];
        d_kind    = d_mem ? i_opcode[10:9] : i_opcode[4:3];
        if (d_illegal) begin
            d_count = 6'd0;
        end else if (d_mem) begin
            d_count = 6'd1;
        end else if (i_opcode[sru_pkg::COUNT_REG_BIT]) begin
            d_count = i_count_register[5:0];
        end else if (i_opcode[11:9] == 3'd0) begin
            d_count = sru_pkg::IMM_ZERO_COUNT;
        end else begin
            d_count = {3'd0, i_opcode[11:9]};
        end
        if (d_illegal) begin
            d_cycles = sru_pkg::CYC_ILLEGAL;
        end else if (d_mem) begin
            d_cycles = sru_pkg::CYC_MEM;
        end else begin
            d_cycles = sru_pkg::CYC_BASE + {1'b0, d_count, 1'b0};
        end
    end

    // one bit step of the shifter
    logic [31:0] s_mask;
    logic [31:0] s_sign;
    logic        s_out;
    logic        s_fill;
    logic        s_ov;
    logic [31:0] n_val;

    always_comb begin
        s_mask = sru_pkg::size_mask(r_size);
        s_sign = sru_pkg::sign_mask(r_size);
        s_ov   = 1'b0;
        if (r_left) begin
            s_out = |(r_val & s_sign);
            unique case (r_kind)
                sru_pkg::KIND_RO:  s_fill = s_out;
                sru_pkg::KIND_ROX: s_fill = r_x;
                default:           s_fill = 1'b0;
            endcase
            n_val = ((r_val << 1) | {31'd0, s_fill}) & s_mask;
            // sign change: old sign differs from the bit moving into it
            s_ov  = (r_kind == sru_pkg::KIND_AS) && (|((r_val ^ (r_val << 1)) & s_sign));
        end else begin
            s_out = r_val[0];
            unique case (r_kind)
                sru_pkg::KIND_RO:  s_fill = s_out;
                sru_pkg::KIND_ROX: s_fill = r_x;
                sru_pkg::KIND_AS:  s_fill = |(r_val & s_sign);
                default:           s_fill = 1'b0;
            endcase
            n_val = (r_val >> 1) | (s_fill ? s_sign : 32'd0);
        end
    end

    assign o_status.count_zero = (r_count == 6'd0);

    // working state: load, then one bit per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val      <= i_operand_value & sru_pkg::size_mask(d_size);
            r_count    <= d_count;
            r_size     <= d_size;
            r_kind     <= d_kind;
            r_left     <= i_opcode[sru_pkg::DIR_LEFT_BIT];
            r_xin      <= i_extend_in;
            r_x        <= i_extend_in;
            r_c        <= 1'b0;
            r_v        <= 1'b0;
            r_zero_cnt <= (d_count == 6'd0);
            r_illegal  <= d_illegal;
            r_cycles   <= d_cycles;
        end else if (i_cmd.step) begin
            r_val   <= n_val;
            r_count <= r_count - 6'd1;
            r_x     <= s_out;
            r_c     <= s_out;
            r_v     <= r_v | s_ov;
        end
    end

    // result registers, written when the shift finishes
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res_size    <= r_size;
            r_res_cycles  <= r_cycles;
            r_res_illegal <= r_illegal;
            if (r_illegal) begin
                r_res_value <= 32'd0;
                r_res_x     <= r_xin;
                r_res_n     <= 1'b0;
                r_res_z     <= 1'b0;
                r_res_v     <= 1'b0;
                r_res_c     <= 1'b0;
            end else begin
                r_res_value <= r_val;
                r_res_x     <= (r_kind == sru_pkg::KIND_RO) ? r_xin : r_x;
                r_res_n     <= |(r_val & s_sign);
                r_res_z     <= (r_val == 32'd0);
                r_res_v     <= r_v;
                // zero count: carry cleared, or copied from extend for rotate through x
                if (r_zero_cnt) begin
                    r_res_c <= (r_kind == sru_pkg::KIND_ROX) ? r_xin : 1'b0;
                end else begin
                    r_res_c <= r_c;
                end
            end
        end
    end

    assign o_result_value = r_res_value;
    assign o_result_size  = r_res_size;
    assign o_flag_x       = r_res_x;
    assign o_flag_n       = r_res_n;
    assign o_flag_z       = r_res_z;
    assign o_flag_v       = r_res_v;
    assign o_flag_c       = r_res_c;
    assign o_cycle_count  = r_res_cycles;
    assign o_illegal      = r_res_illegal;

`ifndef SYNTHESIS
    // each step consumes exactly one count
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !i_cmd.load) |=> (r_count == $past(r_count) - 6'd1))
        else $error("step did not decrement the count");

    // the value never holds bits above its size
    a_val_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.load || i_cmd.step) |-> ((r_val & ~sru_pkg::size_mask(r_size)) == 32'd0))
        else $error("shift value exceeds operand size");

    // step and finish never coincide
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.step && i_cmd.finish))
        else $error("step and finish issued together");
`endif

endmodule

[bench/shift_rotate_unit_test.sv]
// shift_rotate_unit_test: self-checking bench for the shift/rotate unit
// predicts each transaction locally and compares every result strobe against it
// depends on sru_pkg and shift_rotate_unit
`timescale 1ns / 1ps

module shift_rotate_unit_test;

    localparam int TIMEOUT_NS    = 8_000_000;
    localparam int DRAIN_LIMIT   = 200;
    localparam int SETTLE_CYCLES = 70;
    localparam int MAX_REPORTED  = 10;

    // direction and count source bits of the opcode
    localparam logic DIR_RIGHT = 1'b0;
    localparam logic DIR_LEFT  = 1'b1;
    localparam logic CNT_IMM   = 1'b0;
    localparam logic CNT_REG   = 1'b1;

    // effective address modes of the memory form
    localparam logic [2:0] MODE_DATA_REG = 3'd0;
    localparam logic [2:0] MODE_ADDR_REG = 3'd1;
    localparam logic [2:0] MODE_INDIRECT = 3'd2;
    localparam logic [2:0] MODE_POSTINC  = 3'd3;
    localparam logic [2:0] MODE_PREDEC   = 3'd4;
    localparam logic [2:0] MODE_DISP     = 3'd5;
    localparam logic [2:0] MODE_INDEX    = 3'd6;
    localparam logic [2:0] MODE_ABS      = 3'd7;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  size;
        logic        x;
        logic        n;
        logic        z;
        logic        v;
        logic        c;
        logic [7:0]  cycles;
        logic        illegal;
    } t_shift_result;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        start            = 1'b0;
    logic        busy;
    logic [15:0] i_opcode         = '0;
    logic [31:0] i_operand_value  = '0;
    logic [31:0] i_count_register = '0;
    logic        i_extend_in      = 1'b0;
    logic        o_valid;
    logic [31:0] o_result_value;
    logic [1:0]  o_result_size;
    logic        o_flag_x;
    logic        o_flag_n;
    logic        o_flag_z;
    logic        o_flag_v;
    logic        o_flag_c;
    logic [7:0]  o_cycle_count;
    logic        o_illegal;

    t_shift_result expected_results[$];
    int            error_count = 0;

    shift_rotate_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_operand_value  (i_operand_value),
        .i_count_register (i_count_register),
        .i_extend_in      (i_extend_in),
        .o_valid          (o_valid),
        .o_result_value   (o_result_value),
        .o_result_size    (o_result_size),
        .o_flag_x         (o_flag_x),
        .o_flag_n         (o_flag_n),
        .o_flag_z         (o_flag_z),
        .o_flag_v         (o_flag_v),
        .o_flag_c         (o_flag_c),
        .o_cycle_count    (o_cycle_count),
        .o_illegal        (o_illegal)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // bit-serial model of one shift-group instruction
    function automatic t_shift_result predict_shift(input logic [15:0] op,
                                                    input logic [31:0] operand,
                                                    input logic [31:0] count_src,
                                                    input logic xin);
        t_shift_result r;
        logic [1:0]    kind;
        logic [1:0]    size;
        logic          left;
        logic [5:0]    count;
        logic [31:0]   mask;
        logic [31:0]   msb;
        logic [31:0]   v;
        logic [31:0]   prior;
        logic          x;
        logic          c;
        logic          ov;
        logic          out_bit;
        int            i;
        r    = '0;
        left = op[sru_pkg::DIR_LEFT_BIT];
        if (op[7:6] == sru_pkg::SIZE_MEM) begin
            // register-direct modes are not legal for the memory form
            if (op[5:3] == MODE_DATA_REG || op[5:3] == MODE_ADDR_REG) begin
                r.size    = sru_pkg::SIZE_WORD;
                r.x       = xin;
                r.cycles  = sru_pkg::CYC_ILLEGAL;
                r.illegal = 1'b1;
                return r;
            end
            kind     = op[10:9];
            count    = 6'd1;
            size     = sru_pkg::SIZE_WORD;
            r.cycles = sru_pkg::CYC_MEM;
        end else begin
            kind = op[4:3];
            size = op[7:6];
            if (op[sru_pkg::COUNT_REG_BIT]) begin
                count = count_src[5:0];
            end else begin
                count = {3'b000, op[11:9]};
                if (count == 6'd0) count = sru_pkg::IMM_ZERO_COUNT;
            end
            r.cycles = sru_pkg::CYC_BASE + {1'b0, count, 1'b0};
        end

        case (size)
            sru_pkg::SIZE_BYTE: mask = 32'h0000_00FF;
            sru_pkg::SIZE_WORD: mask = 32'h0000_FFFF;
            default:            mask = 32'hFFFF_FFFF;
        endcase
        msb = (mask >> 1) + 32'd1;

        // one bit per pass
        v  = operand & mask;
        x  = xin;
        c  = 1'b0;
        ov = 1'b0;
        for (i = 0; i < count; i++) begin
            if (left) begin
                out_bit = (v & msb) != 0;
                prior   = v;
                case (kind)
                    sru_pkg::KIND_RO:  v = ((v << 1) | {31'd0, out_bit}) & mask;
                    sru_pkg::KIND_ROX: begin
                        v = ((v << 1) | {31'd0, x}) & mask;
                        x = out_bit;
                    end
                    default: begin
                        v = (v << 1) & mask;
                        x = out_bit;
                    end
                endcase
                if (kind == sru_pkg::KIND_AS && ((prior ^ v) & msb) != 0) ov = 1'b1;
            end else begin
                out_bit = v[0];
                case (kind)
                    sru_pkg::KIND_RO:  v = (v >> 1) | (out_bit ? msb : 32'd0);
                    sru_pkg::KIND_ROX: begin
                        v = (v >> 1) | (x ? msb : 32'd0);
                        x = out_bit;
                    end
                    sru_pkg::KIND_AS: begin
                        v = (v >> 1) | (v & msb);
                        x = out_bit;
                    end
                    default: begin
                        v = v >> 1;
                        x = out_bit;
                    end
                endcase
            end
            c = out_bit;
        end

        // zero count: carry cleared, or takes X for rotate through extend
        if (count == 6'd0) c = (kind == sru_pkg::KIND_ROX) ? xin : 1'b0;
        if (kind == sru_pkg::KIND_RO) x = xin;

        r.value = v;
        r.size  = size;
        r.x     = x;
        r.n     = (v & msb) != 0;
        r.z     = (v == 32'd0);
        r.v     = ov;
        r.c     = c;
        return r;
    endfunction

    function automatic logic [15:0] reg_form(input logic [1:0] size, input logic left,
                                             input logic [1:0] kind, input logic count_src,
                                             input logic [2:0] count_field);
        return {4'hE, count_field, left, size, count_src, kind, 3'b000};
    endfunction

    function automatic logic [15:0] mem_form(input logic [1:0] kind, input logic left,
                                             input logic [2:0] mode);
        return {4'hE, 1'b0, kind, left, sru_pkg::SIZE_MEM, mode, 3'b000};
    endfunction

    function automatic string format_result(input t_shift_result r);
        return $sformatf("value %h size %0d xnzvc %b%b%b%b%b cycles %0d illegal %b",
                         r.value, r.size, r.x, r.n, r.z, r.v, r.c, r.cycles, r.illegal);
    endfunction

    task automatic log_error(input string msg);
        if (error_count < MAX_REPORTED) $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // result checker, one strobe per transaction
    always @(posedge i_clk) begin
        t_shift_result got;
        t_shift_result want;
        if (i_rst_n && o_valid) begin
            got = {o_result_value, o_result_size, o_flag_x, o_flag_n, o_flag_z,
                   o_flag_v, o_flag_c, o_cycle_count, o_illegal};
            if (expected_results.size() == 0) begin
                log_error({"unexpected result: ", format_result(got)});
            end else begin
                want = expected_results.pop_front();
                if (got !== want)
                    log_error({"mismatch: expected ", format_result(want),
                               " got ", format_result(got)});
            end
        end
    end

    // send one transaction and wait for it to be taken
    task automatic send_item(input logic [15:0] op, input logic [31:0] operand,
                             input logic [31:0] count_src, input logic xin);
        t_shift_result prediction;
        prediction = predict_shift(op, operand, count_src, xin);
        start            <= 1'b1;
        i_opcode         <= op;
        i_operand_value  <= operand;
        i_count_register <= count_src;
        i_extend_in      <= xin;
        do @(posedge i_clk); while (busy);
        expected_results.push_back(prediction);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // hold off until every pending result has come back or the drain limit runs out
    task automatic drain_results();
        int waited;
        start <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (expected_results.size() != 0 && waited < DRAIN_LIMIT);
        if (expected_results.size() != 0) begin
            log_error($sformatf("%0d results never arrived", expected_results.size()));
            expected_results.delete();
        end
    endtask

    // mostly legal instruction forms with random content, some raw noise
    task automatic send_random_item();
        logic [15:0] op;
        logic [31:0] operand;
        logic [31:0] count_src;
        int          pick;
        op   = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 40) begin
            op[7:6] = 2'($urandom_range(2));
            op[sru_pkg::COUNT_REG_BIT] = CNT_IMM;
        end else if (pick < 70) begin
            op[7:6] = 2'($urandom_range(2));
            op[sru_pkg::COUNT_REG_BIT] = CNT_REG;
        end else if (pick < 88) begin
            op[7:6] = sru_pkg::SIZE_MEM;
            op[5:3] = 3'($urandom_range(MODE_ABS, MODE_INDIRECT));
        end else if (pick < 94) begin
            op[7:6] = sru_pkg::SIZE_MEM;
            op[5:3] = 3'($urandom_range(MODE_ADDR_REG, MODE_DATA_REG));
        end

        case ($urandom_range(7))
            0:       operand = 32'd0;
            1:       operand = 32'hFFFF_FFFF;
            2:       operand = 32'd1 << $urandom_range(31);
            3:       operand = ~(32'd1 << $urandom_range(31));
            default: operand = $urandom;
        endcase

        count_src = $urandom;
        case ($urandom_range(3))
            0: count_src[5:0] = 6'd0;
            1: count_src[5:0] = 6'($urandom_range(8, 1));
            default: ;
        endcase

        send_item(op, operand, count_src, 1'($urandom_range(1)));
    endtask

    // register forms: each kind, direction and size, count edge cases
    task automatic test_register_forms();
        send_item(reg_form(sru_pkg::SIZE_BYTE, DIR_LEFT,  sru_pkg::KIND_AS,  CNT_IMM, 3'd1),
                  32'h0000_0040, 32'd0, 1'b0);
        send_item(reg_form(sru_pkg::SIZE_LONG, DIR_LEFT,  sru_pkg::KIND_AS,  CNT_IMM, 3'd0),
                  32'h0123_4567, 32'd0, 1'b1);
        send_item(reg_form(sru_pkg::SIZE_WORD, DIR_RIGHT, sru_pkg::KIND_AS,  CNT_IMM, 3'd3),
                  32'hAAAA_8001, 32'd0, 1'b0);
        send_item(reg_form(sru_pkg::SIZE_LONG, DIR_LEFT,  sru_pkg::KIND_LS,  CNT_IMM, 3'd1),
                  32'hFFFF_FFFF, 32'd0, 1'b0);
        send_item(reg_form(sru_pkg::SIZE_BYTE, DIR_RIGHT, sru_pkg::KIND_LS,  CNT_IMM, 3'd7),
                  32'hFFFF_FF81, 32'd0, 1'b1);
        send_item(reg_form(sru_pkg::SIZE_WORD, DIR_LEFT,  sru_pkg::KIND_ROX, CNT_IMM, 3'd2),
                  32'h0000_C000, 32'd0, 1'b1);
        send_item(reg_form(sru_pkg::SIZE_LONG, DIR_RIGHT, sru_pkg::KIND_ROX, CNT_IMM, 3'd5),
                  32'h8000_0001, 32'd0, 1'b0);
        send_item(reg_form(sru_pkg::SIZE_BYTE, DIR_LEFT,  sru_pkg::KIND_RO,  CNT_IMM, 3'd4),
                  32'h0000_00F1, 32'd0, 1'b1);
        send_item(reg_form(sru_pkg::SIZE_LONG, DIR_RIGHT, sru_pkg::KIND_RO,  CNT_IMM, 3'd1),
                  32'h0000_0001, 32'd0, 1'b0);
        // longest count, taken modulo 64
        send_item(reg_form(sru_pkg::SIZE_LONG, DIR_LEFT,  sru_pkg::KIND_LS,  CNT_REG, 3'd0),
                  32'h8765_4321, 32'hFFFF_FFFF, 1'b0);
        // register count of 64 acts as zero
        send_item(reg_form(sru_pkg::SIZE_LONG, DIR_RIGHT, sru_pkg::KIND_LS,  CNT_REG, 3'd0),
                  32'h0000_0001, 32'd64, 1'b1);
        send_item(reg_form(sru_pkg::SIZE_BYTE, DIR_LEFT,  sru_pkg::KIND_ROX, CNT_REG, 3'd0),
                  32'h0000_0080, 32'd0, 1'b1);
        send_item(reg_form(sru_pkg::SIZE_WORD, DIR_RIGHT, sru_pkg::KIND_ROX, CNT_REG, 3'd0),
                  32'h0000_0001, 32'd0, 1'b0);
        send_item(reg_form(sru_pkg::SIZE_LONG, DIR_RIGHT, sru_pkg::KIND_RO,  CNT_REG, 3'd0),
                  32'h0000_0000, 32'd0, 1'b1);
        send_item(reg_form(sru_pkg::SIZE_LONG, DIR_LEFT,  sru_pkg::KIND_AS,  CNT_REG, 3'd0),
                  32'h8000_0000, 32'd33, 1'b0);
        send_item(reg_form(sru_pkg::SIZE_LONG, DIR_RIGHT, sru_pkg::KIND_AS,  CNT_REG, 3'd0),
                  32'h8000_0000, 32'hFFFF_FFE0, 1'b0);
    endtask

    // memory forms: one bit on a word, plus the illegal register-direct modes
    task automatic test_memory_forms();
        send_item(mem_form(sru_pkg::KIND_AS,  DIR_LEFT,  MODE_INDIRECT),
                  32'h0000_4000, 32'd0, 1'b0);
        send_item(mem_form(sru_pkg::KIND_AS,  DIR_RIGHT, MODE_POSTINC),
                  32'h0000_8001, 32'd0, 1'b0);
        send_item(mem_form(sru_pkg::KIND_LS,  DIR_LEFT,  MODE_PREDEC),
                  32'hFFFF_8000, 32'd0, 1'b1);
        send_item(mem_form(sru_pkg::KIND_LS,  DIR_RIGHT, MODE_DISP),
                  32'h1234_0001, 32'd0, 1'b0);
        send_item(mem_form(sru_pkg::KIND_ROX, DIR_LEFT,  MODE_INDEX),
                  32'h0000_0000, 32'd0, 1'b1);
        send_item(mem_form(sru_pkg::KIND_ROX, DIR_RIGHT, MODE_ABS),
                  32'h0000_0001, 32'd0, 1'b0);
        send_item(mem_form(sru_pkg::KIND_RO,  DIR_RIGHT, MODE_INDIRECT),
                  32'h0000_0001, 32'd0, 1'b1);
        send_item(mem_form(sru_pkg::KIND_RO,  DIR_LEFT,  MODE_DATA_REG),
                  32'hFFFF_FFFF, 32'd0, 1'b1);
        // ignored opcode bits set on an illegal form
        send_item(mem_form(sru_pkg::KIND_LS,  DIR_RIGHT, MODE_ADDR_REG) | 16'h0807,
                  32'h0000_5555, 32'd0, 1'b0);
    endtask

    // random transactions with sender gaps in some stretches
    task automatic test_random_with_gaps(input int n);
        for (int k = 0; k < n; k++) begin
            send_random_item();
            if ((k % 200) < 140 && $urandom_range(2) == 0)
                idle_cycles($urandom_range(19, 1));
        end
    endtask

    // bursts that wait for the unit to empty out
    task automatic test_pause_for_drain();
        repeat (5) begin
            repeat (20) send_random_item();
            drain_results();
        end
    endtask

    // back-to-back transactions, no sender gaps
    task automatic test_random_back_to_back(input int n);
        repeat (n) send_random_item();
    endtask

    // test sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_forms();
        test_memory_forms();
        test_random_with_gaps(1300);
        test_pause_for_drain();
        test_random_back_to_back(420);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hang guard
    initial begin
        #TIMEOUT_NS;
        $display("Regression FAIL");
        $finish;
    end

endmodule
